>>> rtl/lqr_pkg.sv
// Shared types and constants for the LQR state feedback block.
// No dependencies; imported by every RTL module of the block.
package lqr_pkg;

    localparam logic [2:0] KIND_GAIN  = 3'd0;
    localparam logic [2:0] KIND_MIN   = 3'd1;
    localparam logic [2:0] KIND_MAX   = 3'd2;
    localparam logic [2:0] KIND_FF    = 3'd3;
    localparam logic [2:0] KIND_STATE = 3'd4;

    localparam logic [2:0] REG_STATE_COUNT   = 3'd0;
    localparam logic [2:0] REG_CONTROL_COUNT = 3'd1;
    localparam logic [2:0] REG_CLAMP_ON      = 3'd2;
    localparam logic [2:0] REG_USE_REFERENCE = 3'd3;
    localparam logic [2:0] REG_USE_FF        = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_LIMIT    = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    // Item handed from the front to the back: a classified store write or a
    // state sample, with a flag that says the sample starts a run.
    typedef struct packed {
        logic [2:0]         kind;
        logic [1:0]         row;
        logic [2:0]         column;
        logic signed [32:0] data;
        logic               start;
    } lqr_cmd_t;

endpackage

>>> rtl/lqr_front.sv
// Front end: accepts input items, drops unused kinds, forms the error and
// flags the run trigger. Depends on lqr_pkg.
module lqr_front
    import lqr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         kind,
    input  logic [1:0]         row,
    input  logic [2:0]         column,
    input  logic signed [31:0] value,
    input  logic signed [31:0] reference_value,
    input  logic [3:0]         ns_eff,
    input  logic               use_ref,
    output logic               q_valid,
    input  logic               q_ready,
    output lqr_cmd_t           q_cmd
);

    logic     full_reg;
    lqr_cmd_t cmd_reg;
    lqr_cmd_t cmd_next;
    logic     keep;

    assign in_ready = !full_reg || q_ready;
    assign q_valid  = full_reg;
    assign q_cmd    = cmd_reg;

    // Classify the item and form the error for samples
    always_comb
    begin
        cmd_next.kind   = kind;
        cmd_next.row    = row;
        cmd_next.column = column;
        cmd_next.start  = 1'b0;
        if (kind == KIND_STATE)
        begin
            cmd_next.data  = use_ref ? 33'(value) - 33'(reference_value) : 33'(value);
            cmd_next.start = ({1'b0, column} == ns_eff - 4'd1);
        end
        else
        begin
            cmd_next.data = 33'(value);
        end
        keep = (kind <= KIND_STATE);
    end

    // Hold one item for the queue
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            full_reg <= in_valid && keep;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            cmd_reg <= cmd_next;
        end
    end

endmodule

>>> rtl/lqr_queue.sv
// Two-entry queue between front and back ends.
// Depends on lqr_pkg for the command type.
module lqr_queue
    import lqr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     wr_valid,
    output logic     wr_ready,
    input  lqr_cmd_t wr_cmd,
    output logic     rd_valid,
    input  logic     rd_ready,
    output lqr_cmd_t rd_cmd
);

    lqr_cmd_t   mem_reg [2];
    logic       wp_reg;
    logic       rp_reg;
    logic [1:0] cnt_reg;
    logic       do_wr;
    logic       do_rd;

    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_cmd   = mem_reg[rp_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (do_wr)
            begin
                wp_reg <= !wp_reg;
            end
            if (do_rd)
            begin
                rp_reg <= !rp_reg;
            end
            cnt_reg <= cnt_reg + 2'(do_wr) - 2'(do_rd);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wp_reg] <= wr_cmd;
        end
    end

endmodule

>>> rtl/lqr_back.sv
// Back end: stores gains, limits, feedforward and errors, and runs the
// multiply-accumulate walk per channel. Depends on lqr_pkg.
module lqr_back
    import lqr_pkg::*;
#(
    parameter int MAX_STATES   = 8,
    parameter int MAX_CONTROLS = 4,
    parameter int FRAC_BITS    = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    output logic               q_ready,
    input  lqr_cmd_t           q_cmd,
    input  logic [3:0]         ns_eff,
    input  logic [2:0]         nc_eff,
    input  logic               clamp_on,
    input  logic               use_ff,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] control_value,
    output logic [1:0]         channel,
    output logic               last,
    output logic [1:0]         status
);

    localparam int SW = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1;
    localparam int CW = (MAX_CONTROLS > 1) ? $clog2(MAX_CONTROLS) : 1;
    localparam int GD = MAX_STATES * MAX_CONTROLS;
    localparam int GW = (GD > 1) ? $clog2(GD) : 1;
    localparam logic signed [65:0] TLIM = 66'sh200000000;

    typedef enum logic [2:0] {S_IDLE, S_CHECK, S_FETCH, S_MUL, S_ACC, S_DONE, S_OUT}
        state_t;

    logic signed [31:0] gain_mem [GD];
    logic signed [31:0] min_mem  [MAX_CONTROLS];
    logic signed [31:0] max_mem  [MAX_CONTROLS];
    logic signed [31:0] ff_mem   [MAX_CONTROLS];
    logic signed [32:0] err_mem  [MAX_STATES];

    state_t             state_reg;
    logic [CW:0]        c_reg;
    logic [SW:0]        i_reg;
    logic signed [31:0] g_reg;
    logic signed [32:0] e_reg;
    logic signed [65:0] p_reg;
    logic signed [33:0] acc_reg;
    logic               valid_reg;
    logic signed [31:0] val_reg;
    logic [1:0]         ch_reg;
    logic               last_reg;
    logic [1:0]         st_reg;
    logic [1:0]         err_code_reg;
    logic [CW-1:0]      c_idx;
    logic [GW-1:0]      g_addr;
    logic signed [65:0] term;
    logic signed [34:0] acc_sum;
    logic               lim_bad;
    logic               take;
    logic               emit;
    logic signed [31:0] clamped;

    assign out_valid     = valid_reg;
    assign control_value = val_reg;
    assign channel       = ch_reg;
    assign last          = last_reg;
    assign status        = st_reg;
    assign q_ready       = (state_reg == S_IDLE);
    assign take          = q_valid && q_ready;
    assign c_idx         = c_reg[CW-1:0];
    assign g_addr        = GW'(c_idx * MAX_STATES + i_reg[SW-1:0]);
    assign lim_bad       = clamp_on && (min_mem[c_idx] >= max_mem[c_idx]);
    // A result is loaded only once the output register is free
    assign emit          = (state_reg == S_DONE || state_reg == S_OUT) && (!valid_reg || out_ready);

    // Floor the product term; subtract it from the accumulator
    always_comb
    begin
        term    = p_reg >>> FRAC_BITS;
        acc_sum = 35'(acc_reg) - $signed(term[34:0]);
        if (acc_reg < min_mem[c_idx])
        begin
            clamped = min_mem[c_idx];
        end
        else if (acc_reg > max_mem[c_idx])
        begin
            clamped = max_mem[c_idx];
        end
        else
        begin
            clamped = acc_reg[31:0];
        end
    end

    // Write stores from the queue
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            case (q_cmd.kind)
                KIND_GAIN:
                begin
                    if (32'(q_cmd.row) < MAX_CONTROLS && 32'(q_cmd.column) < MAX_STATES)
                    begin
                        gain_mem[GW'(32'(q_cmd.row) * MAX_STATES + 32'(q_cmd.column))]
                            <= q_cmd.data[31:0];
                    end
                end
                KIND_MIN:
                begin
                    if (32'(q_cmd.row) < MAX_CONTROLS)
                        min_mem[CW'(q_cmd.row)] <= q_cmd.data[31:0];
                end
                KIND_MAX:
                begin
                    if (32'(q_cmd.row) < MAX_CONTROLS)
                        max_mem[CW'(q_cmd.row)] <= q_cmd.data[31:0];
                end
                KIND_FF:
                begin
                    if (32'(q_cmd.row) < MAX_CONTROLS)
                        ff_mem[CW'(q_cmd.row)] <= q_cmd.data[31:0];
                end
                KIND_STATE:
                begin
                    if (32'(q_cmd.column) < MAX_STATES)
                        err_mem[SW'(q_cmd.column)] <= q_cmd.data;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Sequence the run: limit check, then per channel fetch, multiply, subtract
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            valid_reg <= 1'b0;
            c_reg     <= '0;
            i_reg     <= '0;
        end
        else
        begin
            if (valid_reg && out_ready && !emit)
            begin
                valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (take && q_cmd.kind == KIND_STATE && q_cmd.start
                        && 32'(q_cmd.column) < MAX_STATES)
                    begin
                        c_reg     <= '0;
                        state_reg <= S_CHECK;
                    end
                end
                S_CHECK:
                begin
                    if (lim_bad)
                    begin
                        err_code_reg <= ST_LIMIT;
                        state_reg <= S_OUT;
                    end
                    else if (c_reg + 1'b1 >= (CW+1)'(nc_eff))
                    begin
                        c_reg <= '0;
                        i_reg <= '0;
                        acc_reg <= use_ff ? 34'(ff_mem['0]) : '0;
                        state_reg <= S_FETCH;
                    end
                    else
                    begin
                        c_reg <= c_reg + 1'b1;
                    end
                end
                S_FETCH:
                begin
                    g_reg <= gain_mem[g_addr];
                    e_reg <= err_mem[i_reg[SW-1:0]];
                    state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    p_reg <= 66'(g_reg) * 66'(e_reg);
                    state_reg <= S_ACC;
                end
                S_ACC:
                begin
                    if (term > TLIM || term < -TLIM ||
                        acc_sum > 35'sd2147483647 || acc_sum < -35'sd2147483648)
                    begin
                        err_code_reg <= ST_OVERFLOW;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        acc_reg <= acc_sum[33:0];
                        if (i_reg + 1'b1 >= (SW+1)'(ns_eff))
                        begin
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            i_reg <= i_reg + 1'b1;
                            state_reg <= S_FETCH;
                        end
                    end
                end
                S_DONE:
                begin
                    if (emit)
                    begin
                        valid_reg <= 1'b1;
                        val_reg <= clamp_on ? clamped : acc_reg[31:0];
                        ch_reg <= 2'(c_idx);
                        st_reg <= ST_OK;
                        if (c_reg + 1'b1 >= (CW+1)'(nc_eff))
                        begin
                            last_reg <= 1'b1;
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            last_reg <= 1'b0;
                            c_reg <= c_reg + 1'b1;
                            i_reg <= '0;
                            acc_reg <= use_ff ? 34'(ff_mem[CW'(c_reg + 1'b1)]) : '0;
                            state_reg <= S_FETCH;
                        end
                    end
                end
                S_OUT:
                begin
                    if (emit)
                    begin
                        valid_reg <= 1'b1;
                        val_reg <= '0;
                        ch_reg <= 2'(c_idx);
                        last_reg <= 1'b1;
                        st_reg <= err_code_reg;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

>>> rtl/lqr_state_feedback.sv
// Top level of the LQR state feedback regulator: config registers,
// front end, queue and back end. Depends on lqr_pkg and the lqr_* modules.
//
// Channel   Handshake              Payload
// in        in_valid/in_ready      kind, row, column, value, reference_value
// cfg       cfg_valid/cfg_ready    cfg_index, cfg_data
// out       out_valid/out_ready    control_value, channel, last, status
//
// Store writes and non-final samples pass through the front register and the queue.
// A run checks the limit pair of each channel, then per gain term fetches,
// multiplies and subtracts (S_FETCH, S_MUL, S_ACC), and then emits the channel output.
// Reset clears control state only; stores are undefined until written.
// A stalled output holds a run in its output state; the queue keeps taking items until both entries are full.
module lqr_state_feedback
    import lqr_pkg::*;
#(
    parameter int MAX_STATES   = 8,
    parameter int MAX_CONTROLS = 4,
    parameter int FRAC_BITS    = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         kind,
    input  logic [1:0]         row,
    input  logic [2:0]         column,
    input  logic signed [31:0] value,
    input  logic signed [31:0] reference_value,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] control_value,
    output logic [1:0]         channel,
    output logic               last,
    output logic [1:0]         status
);

    logic [3:0] state_count_reg;
    logic [2:0] control_count_reg;
    logic       clamp_on_reg;
    logic       use_ref_reg;
    logic       use_ff_reg;
    logic [3:0] ns_eff;
    logic [2:0] nc_eff;
    logic       fq_valid;
    logic       fq_ready;
    lqr_cmd_t   fq_cmd;
    logic       qb_valid;
    logic       qb_ready;
    lqr_cmd_t   qb_cmd;

    assign cfg_ready = 1'b1;

    // Clip register counts to the usable range
    always_comb
    begin
        ns_eff = state_count_reg;
        if (ns_eff == 4'd0)
            ns_eff = 4'd1;
        else if (32'(ns_eff) > MAX_STATES)
            ns_eff = 4'(MAX_STATES);
        nc_eff = control_count_reg;
        if (nc_eff == 3'd0)
            nc_eff = 3'd1;
        else if (32'(nc_eff) > MAX_CONTROLS)
            nc_eff = 3'(MAX_CONTROLS);
    end

    // Hold configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_count_reg   <= 4'd1;
            control_count_reg <= 3'd1;
            clamp_on_reg      <= 1'b0;
            use_ref_reg       <= 1'b1;
            use_ff_reg        <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_STATE_COUNT:   state_count_reg   <= cfg_data[3:0];
                REG_CONTROL_COUNT: control_count_reg <= cfg_data[2:0];
                REG_CLAMP_ON:      clamp_on_reg      <= cfg_data[0];
                REG_USE_REFERENCE: use_ref_reg       <= cfg_data[0];
                REG_USE_FF:        use_ff_reg        <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    lqr_front u_front (
        .clk, .rst_n, .in_valid, .in_ready, .kind, .row, .column, .value,
        .reference_value, .ns_eff, .use_ref(use_ref_reg),
        .q_valid(fq_valid), .q_ready(fq_ready), .q_cmd(fq_cmd)
    );

    lqr_queue u_queue (
        .clk, .rst_n, .wr_valid(fq_valid), .wr_ready(fq_ready), .wr_cmd(fq_cmd),
        .rd_valid(qb_valid), .rd_ready(qb_ready), .rd_cmd(qb_cmd)
    );

    lqr_back #(
        .MAX_STATES(MAX_STATES), .MAX_CONTROLS(MAX_CONTROLS), .FRAC_BITS(FRAC_BITS)
    ) u_back (
        .clk, .rst_n, .q_valid(qb_valid), .q_ready(qb_ready), .q_cmd(qb_cmd),
        .ns_eff, .nc_eff, .clamp_on(clamp_on_reg), .use_ff(use_ff_reg),
        .out_valid, .out_ready, .control_value, .channel, .last, .status
    );

endmodule

>>> rtl/lqr_checker.sv
// Port-level checker for lqr_state_feedback, bound to the top level.
// Depends on lqr_pkg for status codes.
module lqr_port_checker
    import lqr_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] control_value,
    input logic [1:0]  status,
    input logic        last
);

    // Hold a stalled result
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(control_value))
        else $error("result changed while stalled");

    // Error results end the run
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> last)
        else $error("error result not last");

    // Error results carry zero
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> control_value == 32'd0)
        else $error("error result nonzero");

    // No undefined status code
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == ST_OK || status == ST_LIMIT || status == ST_OVERFLOW))
        else $error("bad status code");

endmodule

bind lqr_state_feedback lqr_port_checker u_lqr_port_checker (
    .clk, .rst_n, .out_valid, .out_ready, .control_value, .status, .last
);
